// ----- sv/pvsl_pkg.sv -----
// Package for the position vector slew limiter.
// Holds widths, register indexes, operation codes and the request, result and config types.
// No dependencies.
package pvsl_pkg;

  localparam int COORD_W       = 32;
  localparam int MAG_W         = COORD_W;
  localparam int PROD_W        = 2 * MAG_W;
  localparam int SUM_W         = 68;
  localparam int ROOT_W        = SUM_W / 2;
  localparam int STEP_W        = 16;
  localparam int QUO_W         = STEP_W;
  localparam int REM_W         = ROOT_W + QUO_W - 1;
  localparam int AXES          = 3;
  localparam int AX_W          = 2;
  localparam int CNT_W         = 6;
  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = STEP_W;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_Z    = 1'b1;

  localparam logic OP_SET_TARGET = 1'b0;
  localparam logic OP_TICK       = 1'b1;

  localparam longint unsigned STEP_MAX = (64'd1 << STEP_W) - 64'd1;

  typedef struct packed {
    logic                      operation;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
  } pvsl_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      at_target;
  } pvsl_res_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_size;
    logic              zero_z_output;
  } pvsl_cfg_t;

endpackage

// ----- sv/pvsl_mul.sv -----
// Registered unsigned multiplier shared by the squaring and scaling steps.
// Depends on pvsl_pkg.
module pvsl_mul (
  input  logic                         clk_i,
  input  logic [pvsl_pkg::MAG_W-1:0]   a_i,
  input  logic [pvsl_pkg::MAG_W-1:0]   b_i,
  output logic [pvsl_pkg::PROD_W-1:0]  prod_o
);
  import pvsl_pkg::*;

  logic [PROD_W-1:0] prod_d, prod_q;

  assign prod_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ----- sv/pvsl_cmpsub.sv -----
// Shared compare-subtract unit used by the square root and the division steps.
// Depends on pvsl_pkg.
module pvsl_cmpsub (
  input  logic [pvsl_pkg::REM_W-1:0] a_i,
  input  logic [pvsl_pkg::REM_W-1:0] b_i,
  output logic                       ge_o,
  output logic [pvsl_pkg::REM_W-1:0] diff_o
);
  import pvsl_pkg::*;

  logic borrow;

  assign {borrow, diff_o} = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o = ~borrow;

endmodule

// ----- sv/pvsl_core.sv -----
// Sequencer and position state of the slew limiter: magnitude, sum of squares,
// bit-pair square root and per-axis restoring division. Depends on pvsl_pkg,
// pvsl_mul and pvsl_cmpsub.
module pvsl_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  pvsl_pkg::pvsl_req_t   req_i,
  input  pvsl_pkg::pvsl_cfg_t   cfg_i,
  input  logic                  out_free_i,
  output logic                  busy_o,
  output logic                  done_o,
  output pvsl_pkg::pvsl_res_t   res_o
);
  import pvsl_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MAG   = 4'd1;
  localparam logic [3:0] ST_SQ    = 4'd2;
  localparam logic [3:0] ST_ACC   = 4'd3;
  localparam logic [3:0] ST_SQRT  = 4'd4;
  localparam logic [3:0] ST_CHK   = 4'd5;
  localparam logic [3:0] ST_DMUL  = 4'd6;
  localparam logic [3:0] ST_DLOAD = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_UPD   = 4'd9;
  localparam logic [3:0] ST_EMIT  = 4'd10;

  localparam logic [AX_W-1:0] AX_LAST = AX_W'(AXES - 1);

  logic [3:0]                state_d, state_q;
  logic [AX_W-1:0]           ax_d, ax_q;
  logic [CNT_W-1:0]          cnt_d, cnt_q;
  logic signed [COORD_W-1:0] cur_d [AXES];
  logic signed [COORD_W-1:0] cur_q [AXES];
  logic signed [COORD_W-1:0] tgt_d [AXES];
  logic signed [COORD_W-1:0] tgt_q [AXES];
  logic [MAG_W-1:0]          mag_d [AXES];
  logic [MAG_W-1:0]          mag_q [AXES];
  logic                      neg_d [AXES];
  logic                      neg_q [AXES];
  logic signed [COORD_W:0]   dif [AXES];
  logic [SUM_W-1:0]          sum_d, sum_q;
  logic [ROOT_W-1:0]         root_d, root_q;
  logic [REM_W-1:0]          rem_d, rem_q;
  logic [REM_W-1:0]          dv_d, dv_q;
  logic [QUO_W-1:0]          quo_d, quo_q;

  logic [MAG_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic [REM_W-1:0]  cs_a, cs_b, cs_diff;
  logic              cs_ge;
  logic [REM_W-1:0]  sq_rem, sq_trial;
  logic [COORD_W-1:0] quo_ext;

  pvsl_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  pvsl_cmpsub u_cmpsub (
    .a_i    (cs_a),
    .b_i    (cs_b),
    .ge_o   (cs_ge),
    .diff_o (cs_diff)
  );

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      dif[i] = {tgt_q[i][COORD_W-1], tgt_q[i]} - {cur_q[i][COORD_W-1], cur_q[i]};
    end
  end

  assign sq_rem   = REM_W'({rem_q[ROOT_W:0], sum_q[SUM_W-1 -: 2]});
  assign sq_trial = REM_W'({root_q, 2'b01});
  assign quo_ext  = COORD_W'(quo_q);

  always_comb begin
    cs_a = rem_q;
    cs_b = dv_q;
    if (state_q == ST_SQRT) begin
      cs_a = sq_rem;
      cs_b = sq_trial;
    end
  end

  always_comb begin
    state_d = state_q;
    ax_d    = ax_q;
    cnt_d   = cnt_q;
    cur_d   = cur_q;
    tgt_d   = tgt_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    sum_d   = sum_q;
    root_d  = root_q;
    rem_d   = rem_q;
    dv_d    = dv_q;
    quo_d   = quo_q;
    mul_a   = mag_q[ax_q];
    mul_b   = '0;
    done_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (req_i.operation == OP_SET_TARGET) begin
            tgt_d[0] = req_i.target_x;
            tgt_d[1] = req_i.target_y;
            tgt_d[2] = req_i.target_z;
            state_d  = ST_EMIT;
          end else begin
            state_d = ST_MAG;
          end
        end
      end
      ST_MAG: begin
        for (int i = 0; i < AXES; i++) begin
          neg_d[i] = dif[i][COORD_W];
          mag_d[i] = dif[i][COORD_W] ? MAG_W'(-dif[i]) : MAG_W'(dif[i]);
        end
        sum_d   = '0;
        ax_d    = '0;
        state_d = ST_SQ;
      end
      ST_SQ: begin
        mul_b   = mag_q[ax_q];
        state_d = ST_ACC;
      end
      ST_ACC: begin
        sum_d = sum_q + SUM_W'(prod);
        if (ax_q == AX_LAST) begin
          root_d  = '0;
          rem_d   = '0;
          cnt_d   = CNT_W'(ROOT_W - 1);
          state_d = ST_SQRT;
        end else begin
          ax_d    = ax_q + 1'b1;
          state_d = ST_SQ;
        end
      end
      ST_SQRT: begin
        if (cs_ge) begin
          rem_d = cs_diff;
        end else begin
          rem_d = sq_rem;
        end
        root_d = {root_q[ROOT_W-2:0], cs_ge};
        sum_d  = sum_q << 2;
        if (cnt_q == '0) begin
          state_d = ST_CHK;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_CHK: begin
        if (root_q > ROOT_W'(cfg_i.step_size)) begin
          ax_d    = '0;
          state_d = ST_DMUL;
        end else begin
          cur_d   = tgt_q;
          state_d = ST_EMIT;
        end
      end
      ST_DMUL: begin
        mul_b   = MAG_W'(cfg_i.step_size);
        state_d = ST_DLOAD;
      end
      ST_DLOAD: begin
        rem_d   = prod[REM_W-1:0];
        dv_d    = REM_W'(root_q) << (QUO_W - 1);
        quo_d   = '0;
        cnt_d   = CNT_W'(QUO_W - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cs_ge) begin
          rem_d = cs_diff;
        end
        quo_d = {quo_q[QUO_W-2:0], cs_ge};
        dv_d  = dv_q >> 1;
        if (cnt_q == '0) begin
          state_d = ST_UPD;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_UPD: begin
        if (neg_q[ax_q]) begin
          cur_d[ax_q] = cur_q[ax_q] - $signed(quo_ext);
        end else begin
          cur_d[ax_q] = cur_q[ax_q] + $signed(quo_ext);
        end
        if (ax_q == AX_LAST) begin
          state_d = ST_EMIT;
        end else begin
          ax_d    = ax_q + 1'b1;
          state_d = ST_DMUL;
        end
      end
      ST_EMIT: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ax_q    <= '0;
      cnt_q   <= '0;
      for (int i = 0; i < AXES; i++) begin
        cur_q[i] <= '0;
        tgt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      tgt_q   <= tgt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    sum_q  <= sum_d;
    root_q <= root_d;
    rem_q  <= rem_d;
    dv_q   <= dv_d;
    quo_q  <= quo_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign res_o.pos_x     = cur_q[0];
  assign res_o.pos_y     = cur_q[1];
  assign res_o.pos_z     = cfg_i.zero_z_output ? '0 : cur_q[2];
  assign res_o.at_target = (cur_q[0] == tgt_q[0]) && (cur_q[1] == tgt_q[1]) &&
                           (cur_q[2] == tgt_q[2]);

endmodule

// ----- sv/position_vector_slew_limiter_top.sv -----
// Top level of the position vector slew limiter: configuration registers,
// request handshake and result register. Depends on pvsl_pkg and pvsl_core.
//
// Each request returns one result. A set-target request goes straight to its
// result; a tick computes the axis differences, the sum of squares through
// the one 32x32 multiplier and the bit-pair square root, and if the length
// exceeds the step size it scales each axis with a 16-step restoring division,
// root and division sharing one compare-subtract unit, before it delivers. The
// input stalls until the result is delivered; the result register lets the next
// request in while a result waits to be taken.
module position_vector_slew_limiter_top #(
  parameter int FRAC_BITS = pvsl_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  pvsl_pkg::pvsl_req_t                in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output pvsl_pkg::pvsl_res_t                out_res_o,
  input  logic                               cfg_we_i,
  input  logic [pvsl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pvsl_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import pvsl_pkg::*;

  localparam longint unsigned STEP_RAW = ((64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [STEP_W-1:0] STEP_RESET =
    (STEP_RAW > STEP_MAX) ? STEP_MAX[STEP_W-1:0] : STEP_RAW[STEP_W-1:0];

  pvsl_cfg_t cfg_d, cfg_q;
  pvsl_res_t core_res;
  pvsl_res_t out_res_q;
  logic      out_valid_d, out_valid_q;
  logic      core_busy, core_done, out_free, start;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign start    = in_valid_i & ~core_busy;

  pvsl_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (in_req_i),
    .cfg_i      (cfg_q),
    .out_free_i (out_free),
    .busy_o     (core_busy),
    .done_o     (core_done),
    .res_o      (core_res)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STEP_SIZE: cfg_d.step_size     = cfg_wdata_i[STEP_W-1:0];
        REG_ZERO_Z:    cfg_d.zero_z_output = cfg_wdata_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (core_done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size     <= STEP_RESET;
      cfg_q.zero_z_output <= 1'b0;
      out_valid_q         <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) begin
      out_res_q <= core_res;
    end
  end

  assign in_stall_o  = core_busy;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  a_busy_after_request : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("core not busy after accepting a request");

  a_done_into_free_slot : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    core_done |-> (in_stall_o && !(out_valid_q && out_stall_i))
  ) else $error("result delivered while result register held and stalled");

endmodule

// ----- test/position_vector_slew_limiter_top_test.sv -----
// Self-checking testbench for position_vector_slew_limiter_top: a scoreboard predicts each
// request's position result, and directed and random target/tick sequences run under several
// register settings and idle patterns. Depends on pvsl_pkg and the block's RTL.
module position_vector_slew_limiter_top_test;
  import pvsl_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 290;
  localparam int unsigned STEP_RESET = ((1 << FRAC_BITS_DEF) + 50) / 100;

  class slew_track;
    longint cur_pos[AXES];
    longint goal_pos[AXES];
    int unsigned step;
    bit zero_z;
    pvsl_res_t expected_positions[$];
    int errors;

    function new();
      step = STEP_RESET;
      zero_z = 1'b0;
      errors = 0;
      foreach (cur_pos[i]) begin
        cur_pos[i] = 0;
        goal_pos[i] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_STEP_SIZE) begin
        step = 32'(data);
      end else if (idx == REG_ZERO_Z) begin
        zero_z = data[0];
      end
    endfunction

    function bit reached();
      return cur_pos[0] == goal_pos[0] && cur_pos[1] == goal_pos[1] &&
             cur_pos[2] == goal_pos[2];
    endfunction

    function logic [33:0] floor_root(logic [67:0] s);
      logic [33:0] r;
      logic [33:0] cand;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
        cand = r | (34'd1 << b);
        if (68'(cand) * 68'(cand) <= s) r = cand;
      end
      return r;
    endfunction

    function void slew_toward_target();
      longint d[AXES];
      logic [32:0] mag[AXES];
      logic [67:0] sum;
      logic [33:0] len;
      longint unsigned q;
      sum = '0;
      for (int i = 0; i < AXES; i++) begin
        d[i] = goal_pos[i] - cur_pos[i];
        mag[i] = (d[i] < 0) ? 33'(-d[i]) : 33'(d[i]);
        sum = sum + 68'(mag[i]) * 68'(mag[i]);
      end
      len = floor_root(sum);
      if (64'(len) > 64'(step)) begin
        for (int i = 0; i < AXES; i++) begin
          q = (64'(mag[i]) * 64'(step)) / 64'(len);
          if (d[i] < 0) cur_pos[i] = cur_pos[i] - longint'(q);
          else cur_pos[i] = cur_pos[i] + longint'(q);
        end
      end else begin
        foreach (cur_pos[i]) cur_pos[i] = goal_pos[i];
      end
    endfunction

    function void note(pvsl_req_t r);
      pvsl_res_t e;
      if (r.operation == OP_SET_TARGET) begin
        goal_pos[0] = longint'(r.target_x);
        goal_pos[1] = longint'(r.target_y);
        goal_pos[2] = longint'(r.target_z);
      end else begin
        slew_toward_target();
      end
      e.pos_x = cur_pos[0][31:0];
      e.pos_y = cur_pos[1][31:0];
      e.pos_z = zero_z ? '0 : cur_pos[2][31:0];
      e.at_target = reached();
      expected_positions.push_back(e);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check(pvsl_res_t got);
      pvsl_res_t want;
      if (expected_positions.size() == 0) begin
        report_mismatch("unexpected result", got.pos_x, '0);
      end else begin
        want = expected_positions.pop_front();
        if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
        if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
        if (got.pos_z !== want.pos_z) report_mismatch("pos_z", got.pos_z, want.pos_z);
        if (got.at_target !== want.at_target) begin
          report_mismatch("at_target", 32'(got.at_target), 32'(want.at_target));
        end
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  pvsl_req_t             in_req_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  pvsl_res_t             out_res_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  slew_track track = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent = 0;
  int quiet_cycles = 0;

  position_vector_slew_limiter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) track.check(out_res_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic offer_request(pvsl_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track.note(r);
    sent++;
  endtask

  task automatic set_target(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    pvsl_req_t r;
    r.operation = OP_SET_TARGET;
    r.target_x = x;
    r.target_y = y;
    r.target_z = z;
    offer_request(r);
  endtask

  task automatic tick_once();
    pvsl_req_t r;
    r.operation = OP_TICK;
    r.target_x = $urandom();
    r.target_y = $urandom();
    r.target_z = $urandom();
    offer_request(r);
  endtask

  function automatic longint near_coord(int axis, int unsigned span);
    longint v;
    v = track.cur_pos[axis] + longint'($urandom_range(2 * span)) - longint'(span);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (track.expected_positions.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] step, bit zz);
    logic [CFG_DATA_W-1:0] zz_word;
    zz_word = CFG_DATA_W'($urandom());
    zz_word[0] = zz;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_STEP_SIZE;
    cfg_wdata_i <= step;
    @(posedge clk_i);
    cfg_idx_i <= REG_ZERO_Z;
    cfg_wdata_i <= zz_word;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    track.write_reg(REG_STEP_SIZE, step);
    track.write_reg(REG_ZERO_Z, zz_word);
  endtask

  task automatic run_random(int count);
    int first;
    int pick;
    int n;
    int unsigned span;
    first = sent;
    while (sent - first < count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        case ($urandom_range(2))
          0: span = 2 * track.step + 3;
          1: span = 40 * track.step + 40;
          default: span = 0;
        endcase
        set_target(32'(near_coord(0, span)), 32'(near_coord(1, span)),
                   32'(near_coord(2, span)));
        n = $urandom_range(1, 40);
        for (int k = 0; k < n; k++) begin
          tick_once();
          if (track.reached() && $urandom_range(3) != 0) break;
        end
      end else if (pick < 85) begin
        tick_once();
      end else if (pick < 97) begin
        set_target($urandom(), $urandom(), $urandom());
        repeat ($urandom_range(0, 3)) tick_once();
      end else begin
        wait_for_results();
        tick_once();
      end
    end
  endtask

  initial begin
    int unsigned step_tab[6];
    bit zz_tab[6];
    int send_tab[6];
    int recv_tab[6];
    step_tab = '{65535, 1, 0, 0, 0, 655};
    zz_tab = '{1, 0, 1, 0, 1, 0};
    send_tab = '{0, 76, 0, 10, 0, 10};
    recv_tab = '{0, 0, 76, 10, 76, 10};
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tick_once();
    set_target(32'd0, 32'd0, 32'd0);
    set_target(32'd655, 32'd0, 32'd0);
    tick_once();
    set_target(32'd1311, 32'd0, 32'd0);
    tick_once();
    tick_once();
    set_target(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    tick_once();
    tick_once();
    set_target(32'h80000000, 32'h80000000, 32'h80000000);
    tick_once();
    set_target(32'h7fffffff, 32'h80000000, 32'h00000000);
    tick_once();
    set_target(32'hffffffff, 32'hffffffff, 32'hffffffff);
    tick_once();
    set_target(32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f);
    tick_once();
    set_target(32'(track.cur_pos[0]), 32'(track.cur_pos[1]), 32'(track.cur_pos[2]));
    tick_once();

    for (int p = 0; p < 6; p++) begin
      wait_for_results();
      if (p == 3 || p == 4) step_tab[p] = $urandom_range(65535);
      if (p == 3) zz_tab[p] = 1'($urandom_range(1));
      program_regs(step_tab[p][CFG_DATA_W-1:0], zz_tab[p]);
      send_idle_pct = send_tab[p];
      recv_stall_pct = recv_tab[p];
      run_random(PHASE_ITEMS);
    end

    wait_for_results();
    repeat (120) @(posedge clk_i);
    if (track.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- position_vector_slew_limiter_top.f -----
sv/pvsl_pkg.sv
sv/pvsl_mul.sv
sv/pvsl_cmpsub.sv
sv/pvsl_core.sv
sv/position_vector_slew_limiter_top.sv
test/position_vector_slew_limiter_top_test.sv
